// ===== rtl/utf8_char_display_width_assert.svh =====
// Assertion macros for the UTF-8 column width block.
// Expects clk and rst in the scope of the module that includes this file.
`ifndef UTF8_CHAR_DISPLAY_WIDTH_ASSERT_SVH
`define UTF8_CHAR_DISPLAY_WIDTH_ASSERT_SVH

// checked only while out of reset
`define UCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define UCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/utf8cw_pkg.sv =====
// Types, width codes and the combining-mark interval table for the UTF-8 column width block.
// No dependencies.
`default_nettype none

package utf8cw_pkg;

  localparam int CP_W     = 21;
  localparam int ZW_COUNT = 100;

  typedef logic [CP_W-1:0] cp_t;
  typedef logic [2:0]      col_width_t;

  typedef struct packed {
    logic bad;
    cp_t  cp;
  } decode_t;

  localparam col_width_t WIDTH_INVALID = 3'b111;
  localparam col_width_t WIDTH_ZERO    = 3'b000;
  localparam col_width_t WIDTH_ONE     = 3'b001;
  localparam col_width_t WIDTH_TWO     = 3'b010;

  localparam cp_t CP_MAX = 21'h10FFFF;

  localparam logic [15:0] ZW_LO [ZW_COUNT] = '{
    16'h0300, 16'h0360, 16'h0483, 16'h0488, 16'h0591, 16'h05A3, 16'h05BB, 16'h05BF,
    16'h05C1, 16'h05C4, 16'h064B, 16'h0670, 16'h06D6, 16'h06E7, 16'h06EA, 16'h070F,
    16'h0711, 16'h0730, 16'h07A6, 16'h0901, 16'h093C, 16'h0941, 16'h094D, 16'h0951,
    16'h0962, 16'h0981, 16'h09BC, 16'h09C1, 16'h09CD, 16'h09E2, 16'h0A02, 16'h0A3C,
    16'h0A41, 16'h0A47, 16'h0A4B, 16'h0A70, 16'h0A81, 16'h0ABC, 16'h0AC1, 16'h0AC7,
    16'h0ACD, 16'h0B01, 16'h0B3C, 16'h0B3F, 16'h0B41, 16'h0B4D, 16'h0B56, 16'h0B82,
    16'h0BC0, 16'h0BCD, 16'h0C3E, 16'h0C46, 16'h0C4A, 16'h0C55, 16'h0CBF, 16'h0CC6,
    16'h0CCC, 16'h0D41, 16'h0D4D, 16'h0DCA, 16'h0DD2, 16'h0DD6, 16'h0E31, 16'h0E34,
    16'h0E47, 16'h0EB1, 16'h0EB4, 16'h0EBB, 16'h0EC8, 16'h0F18, 16'h0F35, 16'h0F37,
    16'h0F39, 16'h0F71, 16'h0F80, 16'h0F86, 16'h0F90, 16'h0F99, 16'h0FC6, 16'h102D,
    16'h1032, 16'h1036, 16'h1039, 16'h1058, 16'h1160, 16'h17B7, 16'h17C6, 16'h17C9,
    16'h180B, 16'h18A9, 16'h200B, 16'h202A, 16'h206A, 16'h20D0, 16'h302A, 16'h3099,
    16'hFB1E, 16'hFE20, 16'hFEFF, 16'hFFF9
  };

  localparam logic [15:0] ZW_HI [ZW_COUNT] = '{
    16'h034E, 16'h0362, 16'h0486, 16'h0489, 16'h05A1, 16'h05B9, 16'h05BD, 16'h05BF,
    16'h05C2, 16'h05C4, 16'h0655, 16'h0670, 16'h06E4, 16'h06E8, 16'h06ED, 16'h070F,
    16'h0711, 16'h074A, 16'h07B0, 16'h0902, 16'h093C, 16'h0948, 16'h094D, 16'h0954,
    16'h0963, 16'h0981, 16'h09BC, 16'h09C4, 16'h09CD, 16'h09E3, 16'h0A02, 16'h0A3C,
    16'h0A42, 16'h0A48, 16'h0A4D, 16'h0A71, 16'h0A82, 16'h0ABC, 16'h0AC5, 16'h0AC8,
    16'h0ACD, 16'h0B01, 16'h0B3C, 16'h0B3F, 16'h0B43, 16'h0B4D, 16'h0B56, 16'h0B82,
    16'h0BC0, 16'h0BCD, 16'h0C40, 16'h0C48, 16'h0C4D, 16'h0C56, 16'h0CBF, 16'h0CC6,
    16'h0CCD, 16'h0D43, 16'h0D4D, 16'h0DCA, 16'h0DD4, 16'h0DD6, 16'h0E31, 16'h0E3A,
    16'h0E4E, 16'h0EB1, 16'h0EB9, 16'h0EBC, 16'h0ECD, 16'h0F19, 16'h0F35, 16'h0F37,
    16'h0F39, 16'h0F7E, 16'h0F84, 16'h0F87, 16'h0F97, 16'h0FBC, 16'h0FC6, 16'h1030,
    16'h1032, 16'h1037, 16'h1039, 16'h1059, 16'h11FF, 16'h17BD, 16'h17C6, 16'h17D3,
    16'h180E, 16'h18A9, 16'h200F, 16'h202E, 16'h206F, 16'h20E3, 16'h302F, 16'h309A,
    16'hFB1E, 16'hFE23, 16'hFEFF, 16'hFFFB
  };

endpackage

`default_nettype wire

// ===== rtl/utf8cw_decode.sv =====
// UTF-8 decoder: lead byte pattern picks the length, continuation low six bits are packed.
// Depends on utf8cw_pkg.
`default_nettype none

module utf8cw_decode import utf8cw_pkg::*; (
  input  wire logic [7:0] lead_byte,
  input  wire logic [7:0] second_byte,
  input  wire logic [7:0] third_byte,
  input  wire logic [7:0] fourth_byte,
  output decode_t         dec
);

  always_comb begin
    dec.bad = 1'b0;
    dec.cp  = '0;
    if (!lead_byte[7]) begin
      dec.cp = {13'd0, lead_byte};
    end else if (lead_byte[7:5] == 3'b110) begin
      dec.cp = {10'd0, lead_byte[4:0], second_byte[5:0]};
    end else if (lead_byte[7:4] == 4'b1110) begin
      dec.cp = {5'd0, lead_byte[3:0], second_byte[5:0], third_byte[5:0]};
    end else if (lead_byte[7:3] == 5'b11110) begin
      dec.cp = {lead_byte[2:0], second_byte[5:0], third_byte[5:0], fourth_byte[5:0]};
    end else begin
      dec.bad = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8cw_classify.sv =====
// Code point classifier: controls, combining intervals, East Asian wide ranges.
// Depends on utf8cw_pkg.
`default_nettype none

module utf8cw_classify import utf8cw_pkg::*; (
  input  wire decode_t     dec,
  output col_width_t       width
);

  logic zw_hit;
  logic is_ctrl;
  logic is_wide;
  cp_t  cp;

  assign cp = dec.cp;

  always_comb begin
    zw_hit = 1'b0;
    for (int i = 0; i < ZW_COUNT; i++) begin
      if (cp[20:16] == 5'd0 && cp[15:0] >= ZW_LO[i] && cp[15:0] <= ZW_HI[i]) begin
        zw_hit = 1'b1;
      end
    end
  end

  assign is_ctrl = (cp < 21'h20) || (cp >= 21'h7F && cp < 21'hA0) || (cp > CP_MAX);

  // CJK block carves out a few punctuation brackets
  assign is_wide = (cp >= 21'h1100 && cp <= 21'h115F) ||
                   (cp >= 21'h2E80 && cp <= 21'hA4CF &&
                    (cp & ~21'h11) != 21'h300A && cp != 21'h303F) ||
                   (cp >= 21'hAC00 && cp <= 21'hD7A3) ||
                   (cp >= 21'hF900 && cp <= 21'hFAFF) ||
                   (cp >= 21'hFE30 && cp <= 21'hFE6F) ||
                   (cp >= 21'hFF00 && cp <= 21'hFF5F) ||
                   (cp >= 21'hFFE0 && cp <= 21'hFFE6) ||
                   (cp >= 21'h20000 && cp <= 21'h2FFFF);

  always_comb begin
    if (dec.bad) begin
      width = WIDTH_INVALID;
    end else if (cp == '0) begin
      width = WIDTH_ZERO;
    end else if (is_ctrl) begin
      width = WIDTH_INVALID;
    end else if (zw_hit) begin
      width = WIDTH_ZERO;
    end else if (is_wide) begin
      width = WIDTH_TWO;
    end else begin
      width = WIDTH_ONE;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/utf8_char_display_width.sv =====
// UTF-8 character display width, top level.
// Input stream: s_tvalid/s_tready/s_tdata, one character (four bytes) per beat.
// Output stream: m_tvalid/m_tready/m_tdata, one column width per beat, signed
// two's complement in m_tdata[2:0]: -1 control or invalid, else 0, 1 or 2.
// Pipeline: an input register, then a result register; m_tvalid comes from the
// result register, and a stall at m_tready can hold a character in either one.
// Throughput: one beat per cycle unless m_tready stalls; the 100 combining intervals
// are compared in parallel, so the classifier sets the cycle time, not the rate.
// Stall: when m_tready is low the result holds and one more character may sit
// in the input register; s_tready falls only when both are full.
// Reset: rst (synchronous, active high) empties both registers; the block
// keeps no other state.
// Depends on utf8cw_pkg, utf8cw_decode, utf8cw_classify and the assert macros.
`default_nettype none
`include "utf8_char_display_width_assert.svh"

module utf8_char_display_width import utf8cw_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // lead_byte, second_byte, third_byte, fourth_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // column_width[2:0], zeros
);

  logic        in_valid;
  logic [31:0] in_data;
  logic        out_valid;
  col_width_t  out_width;
  logic        out_load;
  decode_t     dec;
  col_width_t  width;
  logic        code_legal;

  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata;
    end
  end

  utf8cw_decode u_decode (
    .lead_byte   (in_data[7:0]),
    .second_byte (in_data[15:8]),
    .third_byte  (in_data[23:16]),
    .fourth_byte (in_data[31:24]),
    .dec         (dec)
  );

  utf8cw_classify u_classify (
    .dec   (dec),
    .width (width)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_width <= width;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_width};

  assign code_legal = (m_tdata == {5'd0, WIDTH_INVALID}) || (m_tdata == {5'd0, WIDTH_ZERO}) ||
                      (m_tdata == {5'd0, WIDTH_ONE}) || (m_tdata == {5'd0, WIDTH_TWO});

  `UCW_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid && s_tready, "reset left a beat in flight")
  `UCW_ASSERT(a_advance, in_valid && out_load |=> m_tvalid, "input beat did not reach output")
  `UCW_ASSERT(a_full_stall, in_valid && out_valid && !m_tready |-> !s_tready, "overrun when full")
  `UCW_ASSERT(a_code_legal, m_tvalid |-> code_legal, "bad width code")

endmodule

`default_nettype wire
